[design/sgpa_pkg.sv]
// Shared types, register codes and the short-range weight table for the
// softened gravity pair kernel. No dependencies.
package sgpa_pkg;

  localparam int unsigned DsqW    = 66;   // softened distance squared, Q34.32
  localparam int unsigned ProdW   = 64;   // |d| * mass
  localparam int unsigned RootW   = 49;   // distance, Q.32
  localparam int unsigned XqW     = 21;   // weight table position, 5.16
  localparam int unsigned WeightW = 16;   // weight, Q1.15
  localparam int unsigned QuotW   = 32;   // magnitude before saturation

  localparam logic [WeightW-1:0] WeightOne = 16'd32768;

  typedef enum logic [1:0] {
    REG_SOFTENING = 2'd0,
    REG_CUTOFF    = 2'd1,
    REG_SPLIT     = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] softening_length;
    logic [63:0] cutoff_distance_sq;
    logic [31:0] split_scale;
  } cfg_t;

  // One classified item handed from the front part to the back part
  typedef struct packed {
    logic                  cut;
    logic [2:0]            neg;
    logic [2:0][ProdW-1:0] mm;
    logic [DsqW-1:0]       dsq;
  } fe_t;

  // erfc(x) + 2x/sqrt(pi)*exp(-x*x) in Q1.15, sampled at x = k/8
  function automatic logic [WeightW-1:0] wtab(input logic [5:0] k);
    logic [WeightW-1:0] v;
    case (k)
      6'd0:    v = 16'd32768;
      6'd1:    v = 16'd32720;
      6'd2:    v = 16'd32397;
      6'd3:    v = 16'd31572;
      6'd4:    v = 16'd30110;
      6'd5:    v = 16'd27982;
      6'd6:    v = 16'd25266;
      6'd7:    v = 16'd22121;
      6'd8:    v = 16'd18757;
      6'd9:    v = 16'd15390;
      6'd10:   v = 16'd12214;
      6'd11:   v = 16'd9374;
      6'd12:   v = 16'd6956;
      6'd13:   v = 16'd4991;
      6'd14:   v = 16'd3463;
      6'd15:   v = 16'd2323;
      6'd16:   v = 16'd1508;
      6'd17:   v = 16'd946;
      6'd18:   v = 16'd575;
      6'd19:   v = 16'd337;
      6'd20:   v = 16'd192;
      6'd21:   v = 16'd105;
      6'd22:   v = 16'd56;
      6'd23:   v = 16'd29;
      6'd24:   v = 16'd14;
      6'd25:   v = 16'd7;
      6'd26:   v = 16'd3;
      6'd27:   v = 16'd1;
      6'd28:   v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

[design/sgpa_front.sv]
// Front part: accepts items, forms differences, squares and mass products,
// and classifies each item against the cutoff. Depends on sgpa_pkg.
module sgpa_front import sgpa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] self_x_i,
  input  logic signed [31:0] self_y_i,
  input  logic signed [31:0] self_z_i,
  input  logic signed [31:0] src_x_i,
  input  logic signed [31:0] src_y_i,
  input  logic signed [31:0] src_z_i,
  input  logic        [31:0] src_mass_i,
  output logic               push_o,
  output fe_t                push_data_o,
  input  logic               full_i
);

  logic                  en;
  logic                  v1_q, v2_q, v3_q;
  logic [2:0][31:0]      mag_d, mag_q;
  logic [2:0]            neg_d, neg_q, neg2_q;
  logic [31:0]           mass_q;
  logic [2:0][63:0]      sq_q, mm_q;
  logic [63:0]           ss_q;
  logic [2:0][31:0]      self_v, src_v;
  logic [2:0][32:0]      diff;
  fe_t                   fe_d, fe_q;

  assign en         = !v3_q || !full_i;
  assign in_ready_o = en;
  assign push_o     = v3_q && !full_i;
  assign push_data_o = fe_q;

  assign self_v = {self_z_i, self_y_i, self_x_i};
  assign src_v  = {src_z_i, src_y_i, src_x_i};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i]  = {src_v[i][31], src_v[i]} - {self_v[i][31], self_v[i]};
      neg_d[i] = diff[i][32];
      mag_d[i] = neg_d[i] ? 32'(33'd0 - diff[i]) : diff[i][31:0];
    end
  end

  always_comb begin
    fe_d.neg = neg2_q;
    fe_d.mm  = mm_q;
    fe_d.dsq = {2'b00, sq_q[0]} + {2'b00, sq_q[1]} + {2'b00, sq_q[2]} + {2'b00, ss_q};
    fe_d.cut = (fe_d.dsq[65:64] == 2'b00) && (fe_d.dsq[63:0] <= cfg_i.cutoff_distance_sq);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q  <= mag_d;
      neg_q  <= neg_d;
      mass_q <= src_mass_i;
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= {32'd0, mag_q[i]} * {32'd0, mag_q[i]};
        mm_q[i] <= {32'd0, mag_q[i]} * {32'd0, mass_q};
      end
      ss_q   <= {32'd0, cfg_i.softening_length} * {32'd0, cfg_i.softening_length};
      neg2_q <= neg_q;
      fe_q   <= fe_d;
    end
  end

endmodule

[design/sgpa_fifo.sv]
// Short queue between the front and back parts.
// Depends on sgpa_pkg for the item type.
module sgpa_fifo import sgpa_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  fe_t  push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output fe_t  pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  fe_t             mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth)) else $error("queue count out of range");

endmodule

[design/sgpa_back.sv]
// Back part: pipelined square root, weight, denominator and divisions,
// one stage per root bit, weight table position bit or quotient bit. Depends on sgpa_pkg.
module sgpa_back import sgpa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               fifo_valid_i,
  input  fe_t                fifo_data_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] accel_x_o,
  output logic signed [31:0] accel_y_o,
  output logic signed [31:0] accel_z_o,
  output logic               within_cutoff_o,
  output logic               saturated_o
);

  localparam int unsigned SqFirst = 1;
  localparam int unsigned SqLast  = SqFirst + RootW - 1;
  localparam int unsigned StMul   = SqLast + 1;
  localparam int unsigned StDen   = StMul + 1;
  localparam int unsigned WdFirst = StDen + 1;
  localparam int unsigned WdLast  = WdFirst + XqW - 1;
  localparam int unsigned StTab   = WdLast + 1;
  localparam int unsigned StWgt   = StTab + 1;
  localparam int unsigned StNum   = StWgt + 1;
  localparam int unsigned StSat   = StNum + 1;
  localparam int unsigned DvFirst = StSat + 1;
  localparam int unsigned DvLast  = DvFirst + QuotW - 1;
  localparam int unsigned StFin   = DvLast + 1;
  localparam int unsigned NStg    = StFin + 1;

  typedef struct packed {
    logic                   cut;
    logic [2:0]             neg;
    logic [2:0][ProdW-1:0]  mm;
    logic [DsqW-1:0]        d;
    logic [RootW-1:0]       root;
    logic [97:0]            srem;
    logic [3:0][57:0]       pp;
    logic [114:0]           den;
    logic                   big;
    logic                   wz;
    logic [50:0]            xrem;
    logic [XqW-1:0]         xq;
    logic [WeightW-1:0]     ta;
    logic [31:0]            tp;
    logic [WeightW-1:0]     w;
    logic [2:0][79:0]       num;
    logic [2:0]             qsat;
    logic [2:0][115:0]      drem;
    logic [2:0][QuotW-1:0]  q;
    logic [2:0][31:0]       acc;
    logic                   wc;
    logic                   st;
  } bk_t;

  function automatic bk_t step(input int unsigned idx, input bk_t s, input logic [31:0] split);
    bk_t                 n;
    logic [97:0]         t98;
    logic [52:0]         t53;
    logic [115:0]        r2;
    logic [32:0]         lim;
    logic [31:0]         m;
    logic [5:0]          k;
    logic [WeightW-1:0]  ta, tb;
    logic                sat;
    int unsigned         b;
    n   = s;
    sat = 1'b0;
    if (idx >= SqFirst && idx <= SqLast) begin
      // try the next root bit: (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
      b   = SqLast - idx;
      t98 = ({49'd0, s.root} << (b + 1)) + (98'd1 << (2 * b));
      if (s.srem >= t98) begin
        n.srem = s.srem - t98;
        n.root = s.root | (RootW'(1) << b);
      end
    end else if (idx == StMul) begin
      n.pp[0] = {25'd0, s.d[32:0]}  * {33'd0, s.root[24:0]};
      n.pp[1] = {25'd0, s.d[32:0]}  * {34'd0, s.root[48:25]};
      n.pp[2] = {25'd0, s.d[65:33]} * {33'd0, s.root[24:0]};
      n.pp[3] = {25'd0, s.d[65:33]} * {34'd0, s.root[48:25]};
      n.wz    = (split == '0);
      n.big   = {2'b00, s.root, 2'b00} >= {split, 21'd0};
      n.xrem  = {s.root, 2'b00};
      n.xq    = '0;
    end else if (idx == StDen) begin
      n.den = 115'(s.pp[0]) + (115'(s.pp[1]) << 25) + (115'(s.pp[2]) << 33)
            + (115'(s.pp[3]) << 58);
    end else if (idx >= WdFirst && idx <= WdLast) begin
      b   = WdLast - idx;
      t53 = {21'd0, split} << b;
      if ({2'b00, s.xrem} >= t53) begin
        n.xrem  = s.xrem - t53[50:0];
        n.xq[b] = 1'b1;
      end
    end else if (idx == StTab) begin
      k    = {1'b0, s.xq[20:16]};
      ta   = wtab(k);
      tb   = wtab(k + 6'd1);
      n.ta = ta;
      n.tp = {16'd0, ta - tb} * {16'd0, s.xq[15:0]};
    end else if (idx == StWgt) begin
      if (s.wz)       n.w = WeightOne;
      else if (s.big) n.w = '0;
      else            n.w = s.ta - s.tp[31:16];
    end else if (idx == StNum) begin
      for (int i = 0; i < 3; i++) n.num[i] = {16'd0, s.mm[i]} * {64'd0, s.w};
    end else if (idx == StSat) begin
      // quotient reaches 2^32 exactly when 2*num >= den
      for (int i = 0; i < 3; i++) begin
        n.drem[i] = {35'd0, s.num[i], 1'b0};
        n.qsat[i] = {35'd0, s.num[i], 1'b0} >= {1'b0, s.den};
        n.q[i]    = '0;
      end
    end else if (idx >= DvFirst && idx <= DvLast) begin
      b = DvLast - idx;
      for (int i = 0; i < 3; i++) begin
        r2 = {s.drem[i][114:0], 1'b0};
        if (r2 >= {1'b0, s.den}) begin
          r2        = r2 - {1'b0, s.den};
          n.q[i][b] = 1'b1;
        end
        n.drem[i] = r2;
      end
    end else if (idx == StFin) begin
      for (int i = 0; i < 3; i++) begin
        lim = s.neg[i] ? 33'h080000000 : 33'h07FFFFFFF;
        m   = s.q[i];
        if (s.qsat[i] || ({1'b0, s.q[i]} > lim)) begin
          m   = lim[31:0];
          sat = 1'b1;
        end
        n.acc[i] = s.cut ? 32'd0 : (s.neg[i] ? 32'd0 - m : m);
      end
      n.wc = s.cut;
      n.st = s.cut ? 1'b0 : sat;
    end
    return n;
  endfunction

  logic            en;
  logic [NStg-1:0] vld_q;
  bk_t             pipe_q [NStg];
  bk_t             nxt    [NStg];
  bk_t             in0;

  // hold the whole line while the result waits
  assign en    = !vld_q[NStg-1] || out_ready_i;
  assign pop_o = en && fifo_valid_i;

  always_comb begin
    in0      = '0;
    in0.cut  = fifo_data_i.cut;
    in0.neg  = fifo_data_i.neg;
    in0.mm   = fifo_data_i.mm;
    in0.d    = fifo_data_i.dsq;
    in0.srem = {fifo_data_i.dsq, 32'd0};
  end

  for (genvar g = 0; g < NStg; g++) begin : g_stage
    if (g == 0) begin : g_load
      assign nxt[g] = in0;
    end else begin : g_work
      assign nxt[g] = step(g, pipe_q[g-1], cfg_i.split_scale);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[NStg-2:0], fifo_valid_i};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int g = 0; g < NStg; g++) pipe_q[g] <= nxt[g];
    end
  end

  assign out_valid_o     = vld_q[NStg-1];
  assign accel_x_o       = pipe_q[NStg-1].acc[0];
  assign accel_y_o       = pipe_q[NStg-1].acc[1];
  assign accel_z_o       = pipe_q[NStg-1].acc[2];
  assign within_cutoff_o = pipe_q[NStg-1].wc;
  assign saturated_o     = pipe_q[NStg-1].st;

  a_cut_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && within_cutoff_o |->
      accel_x_o == '0 && accel_y_o == '0 && accel_z_o == '0 && !saturated_o)
    else $error("cutoff result not zero");
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[StDen] && !pipe_q[StDen].cut |-> pipe_q[StDen].den != '0)
    else $error("zero denominator past cutoff");
  a_weight_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[StWgt] |-> pipe_q[StWgt].w <= WeightOne)
    else $error("weight above one");

endmodule

[design/softened_gravity_pair_accel.sv]
// Top level: configuration registers, front part, queue and back part.
// Depends on sgpa_pkg, sgpa_front, sgpa_fifo and sgpa_back.
//
//   channel  signals                           dir  notes
//   in       in_valid_i/in_ready_o, 7 fields   in   positions, mass
//   out      out_valid_o/out_ready_i, 5 fields out  accel, flags
//   cfg      cfg_we_i, cfg_index_i, cfg_value_i in   write only
//
// One item per cycle sustained while results are taken; the back pipeline
// holds the 49-stage root, the 21-stage weight divider and the 32-stage
// quotient pipeline. Reset clears all valid bits and the registers to zero.
// A waiting result stalls the back pipeline; the queue then fills and the
// front drops ready only when its last stage cannot push.
module softened_gravity_pair_accel import sgpa_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [63:0]        cfg_value_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] self_x_i,
  input  logic signed [31:0] self_y_i,
  input  logic signed [31:0] self_z_i,
  input  logic signed [31:0] src_x_i,
  input  logic signed [31:0] src_y_i,
  input  logic signed [31:0] src_z_i,
  input  logic        [31:0] src_mass_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] accel_x_o,
  output logic signed [31:0] accel_y_o,
  output logic signed [31:0] accel_z_o,
  output logic               within_cutoff_o,
  output logic               saturated_o
);

  cfg_t cfg_q;
  logic push, full, pop, fvalid;
  fe_t  push_data, pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SOFTENING: cfg_q.softening_length   <= cfg_value_i[31:0];
        REG_CUTOFF:    cfg_q.cutoff_distance_sq <= cfg_value_i;
        REG_SPLIT:     cfg_q.split_scale        <= cfg_value_i[31:0];
        default: ;
      endcase
    end
  end

  sgpa_front u_front (
    .clk_i, .rst_ni,
    .cfg_i       (cfg_q),
    .in_valid_i, .in_ready_o,
    .self_x_i, .self_y_i, .self_z_i,
    .src_x_i, .src_y_i, .src_z_i, .src_mass_i,
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  sgpa_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i, .rst_ni,
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (fvalid),
    .pop_data_o  (pop_data)
  );

  sgpa_back u_back (
    .clk_i, .rst_ni,
    .cfg_i        (cfg_q),
    .fifo_valid_i (fvalid),
    .fifo_data_i  (pop_data),
    .pop_o        (pop),
    .out_valid_o, .out_ready_i,
    .accel_x_o, .accel_y_o, .accel_z_o,
    .within_cutoff_o, .saturated_o
  );

endmodule
